[rtl/fr16c_pkg.sv]
// Package for the binary32 to ranged 16-bit float converter.
// Holds the rounding mode codes, the random generator constants and the range tables.
// Depends on nothing; used by the core and by its testbench.
package fr16c_pkg;

    // Rounding mode codes as carried on the rounding_mode port.
    typedef enum logic [1:0] {
        RND_RANDOM  = 2'd0,
        RND_UP      = 2'd1,
        RND_NEAREST = 2'd2,
        RND_DOWN    = 2'd3
    } round_mode_t;

    typedef logic [3:0] range_t;
    typedef logic [2:0] ebits_t;

    // Linear congruential generator used by random rounding.
    localparam logic [31:0] LCG_MUL   = 32'd32310901;
    localparam logic [31:0] LCG_ADD   = 32'd1013904223;
    localparam logic [31:0] RNG_RESET = 32'h8765_4321;

    // The generator is kept one step ahead, so reset loads the first drawn value.
    localparam logic [63:0] RNG_FIRST_PROD = 64'(RNG_RESET) * 64'(LCG_MUL);
    localparam logic [31:0] RNG_FIRST      = RNG_FIRST_PROD[31:0] + LCG_ADD;
    localparam logic        RNG_FIRST_PAR  = ^RNG_FIRST;

    // Lowest biased exponent of each range.
    function automatic logic [7:0] range_base(input range_t r);
        logic [7:0] b;
        unique case (r)
            4'd0:    b = 8'd0;
            4'd1:    b = 8'd64;
            4'd2:    b = 8'd96;
            4'd3:    b = 8'd112;
            4'd4:    b = 8'd120;
            4'd5:    b = 8'd124;
            4'd6:    b = 8'd126;
            4'd7:    b = 8'd127;
            4'd8:    b = 8'd128;
            4'd9:    b = 8'd129;
            4'd10:   b = 8'd130;
            4'd11:   b = 8'd132;
            4'd12:   b = 8'd136;
            4'd13:   b = 8'd144;
            4'd14:   b = 8'd160;
            default: b = 8'd192;
        endcase
        return b;
    endfunction

    // Number of exponent offset bits in the 11-bit field of each range.
    function automatic ebits_t range_ebits(input range_t r);
        ebits_t n;
        unique case (r)
            4'd0, 4'd15:               n = 3'd6;
            4'd1, 4'd14:               n = 3'd5;
            4'd2, 4'd13:               n = 3'd4;
            4'd3, 4'd12:               n = 3'd3;
            4'd4, 4'd11:               n = 3'd2;
            4'd5, 4'd10:               n = 3'd1;
            default:                   n = 3'd0;
        endcase
        return n;
    endfunction

endpackage

[rtl/fp32_to_ranged_float16_convert_core.sv]
// Top level of the binary32 to ranged 16-bit float converter.
// Input register, one pass of conversion and rounding logic, result register.
// Depends on fr16c_pkg.
//
//  Channel  | Handshake                   | Payload
//  ---------+-----------------------------+----------------------------------
//  item     | item_valid / item_stall     | float_bits[31:0], rounding_mode[1:0]
//  result   | result_valid / result_stall | result_bits[15:0]
//
// A word enters the input register and moves on to the result register once that
// register is free. One word can be accepted in every cycle while the result side is
// not stalled; the conversion pass between the two registers sets the clock period.
// The random generator is kept one step ahead with its parity stored, so its
// multiply never lies in the conversion path.
// Reset empties both registers and reloads the generator; no clearing pass is needed.
// A stalled result holds the pass; item_stall rises only when both registers are full.
module fp32_to_ranged_float16_convert_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_stall,
    input  logic [31:0] float_bits,
    input  logic [1:0]  rounding_mode,
    output logic        result_valid,
    input  logic        result_stall,
    output logic [15:0] result_bits
);
    import fr16c_pkg::*;

    logic        s0_valid_reg;
    logic [31:0] s0_bits_reg;
    round_mode_t s0_mode_reg;
    logic        res_valid_reg;
    logic [15:0] res_bits_reg;
    logic [31:0] rng_ahead_reg;
    logic        rng_par_reg;

    logic        out_free;
    logic        item_take;
    logic        s0_move;
    logic        rng_step;
    logic [31:0] rng_ahead_next;

    logic [7:0]  exp_field;
    logic [10:0] mant_top;
    range_t      range_sel;
    ebits_t      ebits;
    logic [5:0]  exp_offset;
    logic [16:0] field_wide;
    logic [14:0] mag_trunc;
    logic [18:0] drop_mask;
    logic        drop_any;
    logic        round_bit;
    logic        inc;
    logic [14:0] mag_rounded;
    logic [15:0] res_bits_next;

    // Flow control: the input register moves on whenever the result register frees up.
    assign out_free   = !res_valid_reg || !result_stall;
    assign item_stall = s0_valid_reg && !out_free;
    assign item_take  = item_valid && !item_stall;
    assign s0_move    = s0_valid_reg && out_free;
    assign rng_step   = s0_move && (s0_mode_reg == RND_RANDOM);

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
        end
        else if (item_take)
        begin
            s0_valid_reg <= 1'b1;
        end
        else if (out_free)
        begin
            s0_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_take)
        begin
            s0_bits_reg <= float_bits;
            s0_mode_reg <= round_mode_t'(rounding_mode);
        end
    end

    // Range selection by exponent threshold; the four middle ranges hold one exponent each.
    assign exp_field = s0_bits_reg[30:23];
    assign mant_top  = s0_bits_reg[22:12];

    always_comb
    begin
        priority if (exp_field >= 8'd192) range_sel = 4'd15;
        else if (exp_field >= 8'd160)     range_sel = 4'd14;
        else if (exp_field >= 8'd144)     range_sel = 4'd13;
        else if (exp_field >= 8'd136)     range_sel = 4'd12;
        else if (exp_field >= 8'd132)     range_sel = 4'd11;
        else if (exp_field >= 8'd130)     range_sel = 4'd10;
        else if (exp_field == 8'd129)     range_sel = 4'd9;
        else if (exp_field == 8'd128)     range_sel = 4'd8;
        else if (exp_field == 8'd127)     range_sel = 4'd7;
        else if (exp_field == 8'd126)     range_sel = 4'd6;
        else if (exp_field >= 8'd124)     range_sel = 4'd5;
        else if (exp_field >= 8'd120)     range_sel = 4'd4;
        else if (exp_field >= 8'd112)     range_sel = 4'd3;
        else if (exp_field >= 8'd96)      range_sel = 4'd2;
        else if (exp_field >= 8'd64)      range_sel = 4'd1;
        else                              range_sel = 4'd0;
    end

    // The offset and mantissa share the 11-bit field; the offset always fits its bits,
    // so one right shift of the joined pair places both.
    assign ebits      = range_ebits(range_sel);
    assign exp_offset = 6'(exp_field - range_base(range_sel));
    assign field_wide = {exp_offset, mant_top} >> ebits;
    assign mag_trunc  = {range_sel, field_wide[10:0]};

    // Dropped magnitude bits run from bit 11+eb down to bit 0.
    assign drop_mask = (19'd1 << (5'd12 + 5'(ebits))) - 19'd1;
    assign drop_any  = |({1'b0, s0_bits_reg[17:0]} & drop_mask);
    assign round_bit = s0_bits_reg[5'd11 + 5'(ebits)];

    // Rounding decision; random mode rounds up when the drawn value has even parity.
    always_comb
    begin
        unique case (s0_mode_reg)
            RND_RANDOM:  inc = drop_any && !rng_par_reg;
            RND_UP:      inc = drop_any;
            RND_NEAREST: inc = round_bit;
            RND_DOWN:    inc = 1'b0;
            default:     inc = 1'b0;
        endcase
    end

    // Increment with saturation at the largest magnitude, then reattach the sign.
    assign mag_rounded   = (inc && (mag_trunc != '1)) ? mag_trunc + 15'd1 : mag_trunc;
    assign res_bits_next = {s0_bits_reg[31], mag_rounded};

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            res_valid_reg <= s0_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s0_move)
        begin
            res_bits_reg <= res_bits_next;
        end
    end

    // Random generator, one step ahead, with the parity of the next drawn value.
    assign rng_ahead_next = rng_ahead_reg * LCG_MUL + LCG_ADD;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rng_ahead_reg <= RNG_FIRST;
            rng_par_reg   <= RNG_FIRST_PAR;
        end
        else if (rng_step)
        begin
            rng_ahead_reg <= rng_ahead_next;
            rng_par_reg   <= ^rng_ahead_next;
        end
    end

    assign result_valid = res_valid_reg;
    assign result_bits  = res_bits_reg;

endmodule

[rtl/fr16c_checker.sv]
// Port checker for the ranged 16-bit float converter, bound to its top level.
// Tracks words in flight from the handshakes alone.
// Depends on nothing beyond the top level's ports.
module fr16c_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        item_valid,
    input logic        item_stall,
    input logic [31:0] float_bits,
    input logic [1:0]  rounding_mode,
    input logic        result_valid,
    input logic        result_stall,
    input logic [15:0] result_bits
);
    logic       in_acc;
    logic       out_acc;
    logic [2:0] inflight_reg;

    assign in_acc  = item_valid && !item_stall;
    assign out_acc = result_valid && !result_stall;

    // Words accepted but not yet delivered.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inflight_reg <= 3'd0;
        end
        else
        begin
            inflight_reg <= inflight_reg + 3'(in_acc) - 3'(out_acc);
        end
    end

    // The block holds at most two words: the input and the result register.
    a_inflight_max: assert property (@(posedge clk) disable iff (!rst_n)
        inflight_reg <= 3'd2)
        else $error("more than two words in flight");

    // A result is only shown for a word that was accepted.
    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> inflight_reg != 3'd0)
        else $error("result shown with no word in flight");

    // The input side stalls only when a result is held back.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> result_valid && result_stall)
        else $error("input stalled while result side is free");

    // A stalled result stays put.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result_bits))
        else $error("stalled result changed");

    // A stalled input word stays put until it is taken.
    a_item_hold: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_stall |=>
            item_valid && $stable(float_bits) && $stable(rounding_mode))
        else $error("stalled input word changed");

endmodule

bind fp32_to_ranged_float16_convert_core fr16c_checker u_fr16c_checker (.*);

[dv/fp32_to_ranged_float16_convert_core_tb.sv]
// Self-checking testbench for the binary32 to ranged 16-bit float converter.
// Drives words with random gaps, stalls results at random and predicts every result
// with a local model of the converter. Depends on fr16c_pkg and the core RTL.
module fp32_to_ranged_float16_convert_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import fr16c_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        item_valid = 1'b0;
    logic        item_stall;
    logic [31:0] float_bits = '0;
    logic [1:0]  rounding_mode = RND_DOWN;
    logic        result_valid;
    logic        result_stall = 1'b0;
    logic [15:0] result_bits;

    // Predicted results in order, the mirrored generator state and the error count.
    logic [15:0] expected_words[$];
    logic [31:0] rng_state = RNG_RESET;
    logic [15:0] want_word;
    int          fail_count = 0;
    bit          idle_on = 1'b1;

    fp32_to_ranged_float16_convert_core u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (item_valid),
        .item_stall    (item_stall),
        .float_bits    (float_bits),
        .rounding_mode (rounding_mode),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .result_bits   (result_bits)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Lowest biased exponent that falls into range r.
    function automatic logic [7:0] range_floor(input logic [3:0] r);
        case (r)
            4'd0:    return 8'd0;
            4'd1:    return 8'd64;
            4'd2:    return 8'd96;
            4'd3:    return 8'd112;
            4'd4:    return 8'd120;
            4'd5:    return 8'd124;
            4'd6:    return 8'd126;
            4'd7:    return 8'd127;
            4'd8:    return 8'd128;
            4'd9:    return 8'd129;
            4'd10:   return 8'd130;
            4'd11:   return 8'd132;
            4'd12:   return 8'd136;
            4'd13:   return 8'd144;
            4'd14:   return 8'd160;
            default: return 8'd192;
        endcase
    endfunction

    // Highest range whose floor the exponent reaches; the floors rise with the code.
    function automatic logic [3:0] exp_to_range(input logic [7:0] e);
        logic [3:0] r;
        r = 4'd0;
        for (int i = 1; i < 16; i++)
        begin
            if (e >= range_floor(4'(i)))
                r = 4'(i);
        end
        return r;
    endfunction

    // Converts one word and advances the generator when random rounding is asked for.
    function automatic logic [15:0] predict_ranged16(input logic [31:0] bits,
                                                     input round_mode_t mode);
        logic [7:0]  e;
        logic [3:0]  r;
        int          eb;
        logic [31:0] acc;
        logic [31:0] round_mask;
        logic [31:0] drop_mask;
        logic [31:0] mag;
        logic        bump;
        e = bits[30:23];
        r = exp_to_range(e);
        eb = (r < 4'd6) ? 6 - int'(r) : ((r > 4'd9) ? int'(r) - 9 : 0);
        acc = (32'(e - range_floor(r)) << (11 - eb)) | (32'(bits[22:12]) >> eb)
            | (32'(r) << 11);
        acc &= 32'h7FFF;
        round_mask = 32'd1 << (11 + eb);
        drop_mask = (round_mask << 1) - 32'd1;
        mag = {1'b0, bits[30:0]};
        bump = 1'b0;
        case (mode)
            RND_RANDOM:
            begin
                rng_state = rng_state * LCG_MUL + LCG_ADD;
                if (^rng_state == 1'b0)
                    bump = (mag & drop_mask) != 0;
            end
            RND_UP:      bump = (mag & drop_mask) != 0;
            RND_NEAREST: bump = (mag & round_mask) != 0;
            default:     bump = 1'b0;
        endcase
        // A carry past the top range saturates the magnitude.
        if (bump)
        begin
            acc += 32'd1;
            if (acc > 32'h7FFF)
                acc = 32'h7FFF;
        end
        return {bits[31], acc[14:0]};
    endfunction

    // Sends one word after a random gap and records its prediction once accepted.
    task automatic send_word(input logic [31:0] bits, input round_mode_t mode);
        int gap;
        gap = idle_on ? $urandom_range(0, 3) : 0;
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        float_bits <= bits;
        rounding_mode <= mode;
        do
            @(posedge clk);
        while (item_stall);
        expected_words.push_back(predict_ranged16(bits, mode));
    endtask

    // Result side: stall for a random count per word, then wait for the word.
    initial
    begin
        int hold;
        forever
        begin
            hold = idle_on ? $urandom_range(0, 3) : 0;
            if (hold > 0)
            begin
                result_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            result_stall <= 1'b0;
            do
                @(posedge clk);
            while (result_valid !== 1'b1);
        end
    end

    // Compare each accepted result word with the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            if (expected_words.size() == 0)
            begin
                $display("%0t: unexpected result word, actual %h", $time, result_bits);
                fail_count++;
            end
            else
            begin
                want_word = expected_words.pop_front();
                if (result_bits !== want_word)
                begin
                    $display("%0t: result_bits mismatch, expected %h, actual %h",
                             $time, want_word, result_bits);
                    fail_count++;
                end
            end
        end
    end

    // Zero, signed zero, the smallest subnormal, infinity and a NaN.
    task automatic test_special_values();
        send_word(32'h0000_0000, RND_DOWN);
        send_word(32'h8000_0000, RND_UP);
        send_word(32'h0000_0001, RND_UP);
        send_word(32'h7F80_0000, RND_NEAREST);
        send_word(32'hFFC0_0001, RND_RANDOM);
    endtask

    // Lower bits set under every mode; round bit set except in the nearest case.
    task automatic test_rounding_modes();
        send_word(32'h3F80_0C01, RND_RANDOM);
        send_word(32'h3F80_0C01, RND_UP);
        send_word(32'h3F80_0401, RND_NEAREST);
        send_word(32'h3F80_0C01, RND_DOWN);
    endtask

    // Rounding at all-ones saturates; at the top of a lower range it moves up a range.
    task automatic test_saturation();
        send_word(32'h7FFF_FFFF, RND_UP);
        send_word(32'hFFFF_FFFF, RND_NEAREST);
        send_word(32'h3EFF_FFFF, RND_UP);
    endtask

    // The first exponent of every range above range 0.
    task automatic test_range_edges();
        for (int r = 1; r < 16; r++)
            send_word({r[0], range_floor(4'(r)), 23'($urandom())},
                      round_mode_t'($urandom_range(0, 3)));
    endtask

    // Random words: plain patterns, exponents around range edges, specials and carries.
    task automatic test_random_traffic(input int count);
        logic [31:0] bits;
        logic [7:0]  e;
        for (int n = 0; n < count; n++)
        begin
            bits = $urandom();
            case ($urandom_range(0, 3))
                0: ;
                1:
                begin
                    e = range_floor(4'($urandom_range(1, 15))) + 8'($urandom_range(0, 2)) - 8'd1;
                    bits[30:23] = e;
                end
                2: bits[30:23] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                default: bits[22:12] = 11'h7FF;
            endcase
            send_word(bits, round_mode_t'($urandom_range(0, 3)));
        end
    endtask

    // A stretch of words with no gaps and no stalls on either side.
    task automatic test_back_to_back(input int count);
        idle_on = 1'b0;
        test_random_traffic(count);
        idle_on = 1'b1;
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_special_values();
        test_rounding_modes();
        test_saturation();
        test_range_edges();
        test_random_traffic(600);
        test_back_to_back(200);
        item_valid <= 1'b0;
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Hard limit on run time.
    initial
    begin
        #500_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
